// ===== rtl/base32_stream_decoder_top_defines.svh =====
// Assertion macros for the Base32 stream decoder.
// Used by base32_stream_decoder_top; empty bodies when SYNTHESIS is defined.
`ifndef BASE32_STREAM_DECODER_TOP_DEFINES_SVH
`define BASE32_STREAM_DECODER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define B32SD_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("b32sd assertion failed");
`define B32SD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("b32sd assertion failed");
`else
`define B32SD_ASSERT_HOLDS(label, clk, rst, ante, cons)
`define B32SD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/b32sd_pkg.sv =====
// Shared types and constants of the Base32 stream decoder.
// No dependencies.
`timescale 1ns / 1ps

package b32sd_pkg;

   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_PAD   = 8'h3D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_TWO   = 8'h32;
   localparam logic [7:0] CHAR_SEVEN = 8'h37;
   localparam logic [7:0] CHAR_EIGHT = 8'h38;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_B  = 8'h42;
   localparam logic [7:0] CHAR_UP_L  = 8'h4C;
   localparam logic [7:0] CHAR_UP_O  = 8'h4F;
   localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
   localparam logic [7:0] CHAR_LO_A  = 8'h61;
   localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
   // '2' - 26: digits 2..7 map to symbols 26..31
   localparam logic [7:0] DIGIT_BASE = 8'd24;

   localparam int WIN_W  = 12;
   localparam int SYM_W  = 5;
   localparam int HELD_W = 3;
   localparam int BYTE_W = 8;
   localparam int SHOW_W = 16;

   typedef struct packed {
      logic             is_nul;
      logic             skip;
      logic             invalid;
      logic [SYM_W-1:0] value;
   } sym_type;

   typedef struct packed {
      logic    valid;
      logic    new_string;
      sym_type sym;
   } stage_type;

   typedef struct packed {
      logic failed;
      logic has_result;
      logic advance;
   } status_type;

endpackage

// ===== rtl/b32sd_if.sv =====
// Valid/ready channel interfaces for the decoder's character and result streams.
// Depends on nothing.
`timescale 1ns / 1ps

interface b32sd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       new_string;

   modport source (output valid, char_code, new_string, input ready);
   modport sink (input valid, char_code, new_string, output ready);
endinterface

interface b32sd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  data_byte;
   logic [15:0] byte_count;

   modport source (output valid, kind, data_byte, byte_count, input ready);
   modport sink (input valid, kind, data_byte, byte_count, output ready);
endinterface

// ===== rtl/base32_stream_decoder_top.sv =====
// Base32 stream decoder: character input register, classifier and decoder core.
// Path: a character enters the input register, and its result the result register.
// Throughput: one character per cycle; set by the single input and result registers.
// A character waits in the input register only while the result register is full.
// Reset (synchronous, active high) clears the window, held bits, count and failure.
// Depends on b32sd_pkg, b32sd_if, b32sd_sym_map, b32sd_core and the defines header.
`timescale 1ns / 1ps
`include "base32_stream_decoder_top_defines.svh"

module base32_stream_decoder_top #(
   parameter int COUNT_WIDTH = 16
) (
   input logic          clock,
   input logic          reset,
   b32sd_req_if.sink    req_if,
   b32sd_rsp_if.source  rsp_if
);

   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_char_ff;
   logic                  in_new_ff;
   logic                  req_take;
   b32sd_pkg::sym_type    sym;
   b32sd_pkg::stage_type  stage;
   b32sd_pkg::status_type status;

   assign req_if.ready = !in_valid_ff || status.advance;
   assign req_take     = req_if.valid && req_if.ready;
   assign in_valid_in  = req_take ? 1'b1 : (status.advance ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req_if.char_code;
         in_new_ff  <= req_if.new_string;
      end
   end

   b32sd_sym_map u_sym_map (
      .char_code (in_char_ff),
      .sym       (sym)
   );

   assign stage.valid      = in_valid_ff;
   assign stage.new_string = in_new_ff;
   assign stage.sym        = sym;

   b32sd_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .stage     (stage),
      .out_ready (rsp_if.ready),
      .out_valid (rsp_if.valid),
      .out_kind  (rsp_if.kind),
      .out_byte  (rsp_if.data_byte),
      .out_count (rsp_if.byte_count),
      .status    (status)
   );

   `B32SD_ASSERT_HOLDS(a_nondata_zero_byte, clock, reset,
      rsp_if.valid && (rsp_if.kind != b32sd_pkg::KIND_DATA), rsp_if.data_byte == 8'd0)
   `B32SD_ASSERT_HOLDS(a_failed_silent, clock, reset,
      in_valid_ff && status.failed, !status.has_result)
   `B32SD_ASSERT_HOLDS(a_data_counted, clock, reset,
      rsp_if.valid && (rsp_if.kind == b32sd_pkg::KIND_DATA), rsp_if.byte_count != 16'd0)
   `B32SD_ASSERT_NEXT(a_stall_holds_char, clock, reset,
      in_valid_ff && !status.advance, in_valid_ff && $stable(in_char_ff))

endmodule

// ===== rtl/b32sd_sym_map.sv =====
// Character classifier: maps one ASCII code to a Base32 symbol or class.
// Depends on b32sd_pkg.
`timescale 1ns / 1ps

module b32sd_sym_map (
   input  logic [7:0]        char_code,
   output b32sd_pkg::sym_type sym
);

   logic [7:0] mapped;

   always_comb begin
      mapped = char_code;
      if (char_code == b32sd_pkg::CHAR_ZERO) begin
         mapped = b32sd_pkg::CHAR_UP_O;
      end else if (char_code == b32sd_pkg::CHAR_ONE) begin
         mapped = b32sd_pkg::CHAR_UP_L;
      end else if (char_code == b32sd_pkg::CHAR_EIGHT) begin
         mapped = b32sd_pkg::CHAR_UP_B;
      end
   end

   always_comb begin
      sym = '0;
      case (mapped) inside
         b32sd_pkg::CHAR_NUL: begin
            sym.is_nul = 1'b1;
         end
         b32sd_pkg::CHAR_SPACE, b32sd_pkg::CHAR_TAB, b32sd_pkg::CHAR_CR,
         b32sd_pkg::CHAR_LF, b32sd_pkg::CHAR_DASH, b32sd_pkg::CHAR_PAD: begin
            sym.skip = 1'b1;
         end
         [b32sd_pkg::CHAR_UP_A:b32sd_pkg::CHAR_UP_Z],
         [b32sd_pkg::CHAR_LO_A:b32sd_pkg::CHAR_LO_Z]: begin
            sym.value = mapped[b32sd_pkg::SYM_W-1:0] - 5'd1;
         end
         [b32sd_pkg::CHAR_TWO:b32sd_pkg::CHAR_SEVEN]: begin
            sym.value = b32sd_pkg::SYM_W'(mapped - b32sd_pkg::DIGIT_BASE);
         end
         default: begin
            sym.invalid = 1'b1;
         end
      endcase
   end

endmodule

// ===== rtl/b32sd_core.sv =====
// Decoder state (bit window, held bits, count, failure) and result register.
// Depends on b32sd_pkg.
`timescale 1ns / 1ps

module b32sd_core #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  b32sd_pkg::stage_type    stage,
   input  logic                    out_ready,
   output logic                    out_valid,
   output logic [1:0]              out_kind,
   output logic [7:0]              out_byte,
   output logic [15:0]             out_count,
   output b32sd_pkg::status_type   status
);

   localparam int WW = b32sd_pkg::WIN_W;
   localparam int HW = b32sd_pkg::HELD_W;
   localparam int SW = b32sd_pkg::SHOW_W;
   localparam int EW = COUNT_WIDTH + SW;

   logic [WW-1:0]          window_ff, window_in, win_cur, win_shift;
   logic [HW-1:0]          held_ff, held_in, held_cur;
   logic [COUNT_WIDTH-1:0] count_ff, count_in, cnt_cur, cnt_inc;
   logic                   failed_ff, failed_in, failed_cur;
   logic                   out_valid_ff, out_valid_in;
   logic [1:0]             out_kind_ff, kind_res;
   logic [7:0]             out_byte_ff, byte_res;
   logic [SW-1:0]          out_count_ff, count_show;
   logic [EW-1:0]          count_ext;
   logic [HW:0]            held_sum;
   logic                   has_res, advance;

   assign win_cur    = stage.new_string ? '0 : window_ff;
   assign held_cur   = stage.new_string ? '0 : held_ff;
   assign cnt_cur    = stage.new_string ? '0 : count_ff;
   assign failed_cur = stage.new_string ? 1'b0 : failed_ff;

   assign win_shift = {win_cur[WW-b32sd_pkg::SYM_W-1:0], stage.sym.value};
   assign held_sum  = {1'b0, held_cur} + (HW+1)'(b32sd_pkg::SYM_W);
   assign cnt_inc   = (cnt_cur != '1) ? COUNT_WIDTH'(cnt_cur + 1'b1) : cnt_cur;

   always_comb begin
      window_in = win_cur;
      held_in   = held_cur;
      count_in  = cnt_cur;
      failed_in = failed_cur;
      has_res   = 1'b0;
      kind_res  = b32sd_pkg::KIND_DATA;
      byte_res  = '0;
      if (!failed_cur) begin
         if (stage.sym.is_nul) begin
            window_in = '0;
            held_in   = '0;
            has_res   = 1'b1;
            kind_res  = b32sd_pkg::KIND_END;
         end else if (stage.sym.skip) begin
            has_res = 1'b0;
         end else if (stage.sym.invalid) begin
            failed_in = 1'b1;
            has_res   = 1'b1;
            kind_res  = b32sd_pkg::KIND_ERROR;
         end else begin
            window_in = win_shift;
            // sum stays below 13, so the low bits are the remainder after a byte
            held_in   = held_sum[HW-1:0];
            if (held_sum[HW]) begin
               has_res  = 1'b1;
               byte_res = 8'(win_shift >> held_sum[HW-1:0]);
               count_in = cnt_inc;
            end
         end
      end
   end

   assign count_ext  = {{SW{1'b0}}, count_in};
   assign count_show = (count_ext > EW'({SW{1'b1}})) ? {SW{1'b1}} : count_ext[SW-1:0];

   assign advance      = stage.valid && (!has_res || !out_valid_ff || out_ready);
   assign out_valid_in = (advance && has_res) ? 1'b1 : (out_ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= '0;
         held_ff      <= '0;
         count_ff     <= '0;
         failed_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (advance) begin
            window_ff <= window_in;
            held_ff   <= held_in;
            count_ff  <= count_in;
            failed_ff <= failed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && has_res) begin
         out_kind_ff  <= kind_res;
         out_byte_ff  <= byte_res;
         out_count_ff <= count_show;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_kind  = out_kind_ff;
   assign out_byte  = out_byte_ff;
   assign out_count = out_count_ff;

   assign status.failed     = failed_cur;
   assign status.has_result = has_res;
   assign status.advance    = advance;

endmodule
